@@ rtl/tqps_pkg.sv @@
// Shared types, codes and constants of the two-queue page I/O scheduler.
package tqps_pkg;

  localparam int TAG_W  = 4;
  localparam int TYPE_W = 3;
  localparam int ERR_W  = 2;

  // Request type codes as they arrive on the input channel
  localparam logic [TYPE_W-1:0] REQ_ENQ_PAGEIN  = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_ENQ_PAGEOUT = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_RAISE       = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_DEQ_PAGEOUT = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_IO_DONE     = 3'd4;

  // Error codes of a result
  localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_QUEUED = 2'd1;
  localparam logic [ERR_W-1:0] ERR_IDLE   = 2'd2;

  // Command queue between front and back
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PW    = 1;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [TAG_W-1:0]  req_tag;
  } req_t;

  typedef struct packed {
    logic             start_valid;
    logic [TAG_W-1:0] start_tag;
    logic             start_is_write;
    logic             done_valid;
    logic [TAG_W-1:0] done_tag;
    logic             done_was_write;
    logic             dequeued;
    logic [ERR_W-1:0] error_code;
  } rsp_t;

  // Classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_NOP,
    OP_ENQ_IN,
    OP_ENQ_OUT,
    OP_RAISE,
    OP_DEQ,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [TAG_W-1:0] tag;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENQ_LINK,
    ST_START,
    ST_HEAD,
    ST_WALK,
    ST_SPLICE,
    ST_RAISE_FRONT,
    ST_DEQ_HEAD,
    ST_OUT
  } st_t;

endpackage

@@ rtl/two_queue_page_io_scheduler.sv @@
// Top level: strict-priority page-in/page-out scheduler with one transfer in flight.
// Raise and dequeue walk the page-out list one link per cycle through the link memory
// read port. The back sequencer takes a new request only after the result of the last
// one has been taken; the front queue holds two more. Synchronous active-high reset
// empties both queues, clears membership flags and the in-flight transfer; the link
// memory is not cleared.
module two_queue_page_io_scheduler
  import tqps_pkg::*;
#(
  parameter int NUM_TAGS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  tqps_front #(
    .NUM_TAGS (NUM_TAGS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  tqps_back #(
    .NUM_TAGS (NUM_TAGS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

@@ rtl/tqps_front.sv @@
// Front end: accepts requests, classifies them and buffers them in a short command queue.
module tqps_front
  import tqps_pkg::*;
#(
  parameter int NUM_TAGS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  cmd_t              cls;
  logic              tag_ok;
  logic              push;
  logic              pop;
  cmd_t              cmd_q [CMD_DEPTH];
  logic [CMD_PW-1:0] wr_ptr;
  logic [CMD_PW-1:0] rd_ptr;
  logic [CMD_PW:0]   fill;

  // Classify: unknown types and out-of-range tags become no-ops; I/O done keeps its op whatever its tag
  assign tag_ok = int'(req.req_tag) < NUM_TAGS;

  always_comb begin
    cls.tag = req.req_tag;
    unique case (req.req_type)
      REQ_ENQ_PAGEIN:  cls.op = OP_ENQ_IN;
      REQ_ENQ_PAGEOUT: cls.op = OP_ENQ_OUT;
      REQ_RAISE:       cls.op = OP_RAISE;
      REQ_DEQ_PAGEOUT: cls.op = OP_DEQ;
      REQ_IO_DONE:     cls.op = OP_DONE;
      default:         cls.op = OP_NOP;
    endcase
    if (cls.op != OP_DONE && !tag_ok) begin
      cls.op = OP_NOP;
    end
  end

  assign req_ready = fill != (CMD_PW+1)'(CMD_DEPTH);
  assign cmd_valid = fill != '0;
  assign cmd       = cmd_q[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = cmd_valid && cmd_ready;

  // Advance queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + CMD_PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + CMD_PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (CMD_PW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (CMD_PW+1)'(1);
      end
    end
  end

  // Store classified request
  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr] <= cls;
    end
  end

endmodule

@@ rtl/tqps_back.sv @@
// Back end: sequencer over the linked queues, link memory and result register.
module tqps_back
  import tqps_pkg::*;
#(
  parameter int NUM_TAGS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int IW    = $clog2(NUM_TAGS);
  localparam int CNT_W = $clog2(NUM_TAGS + 1);

  st_t                state, state_next;
  op_t                op, op_next;
  logic [TAG_W-1:0]   tag, tag_next;
  logic [TAG_W-1:0]   rhead, rhead_next, rtail, rtail_next;
  logic [TAG_W-1:0]   whead, whead_next, wtail, wtail_next;
  logic [CNT_W-1:0]   rcount, rcount_next, wcount, wcount_next;
  logic               busy, busy_next, busy_wr, busy_wr_next;
  logic [TAG_W-1:0]   cur_tag, cur_tag_next;
  logic [TAG_W-1:0]   walk_cur, walk_cur_next;
  logic [CNT_W-1:0]   walk_pos, walk_pos_next;
  logic [TAG_W-1:0]   pred, pred_next;
  logic               take_wr, take_wr_next;
  logic [NUM_TAGS-1:0] pin, pin_next, pout, pout_next;
  rsp_t               res, res_next;

  logic [TAG_W-1:0]   link_mem [NUM_TAGS];
  logic [TAG_W-1:0]   link_rd;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [TAG_W-1:0]   mem_wdata;
  logic [IW-1:0]      mem_raddr;
  logic [IW-1:0]      cix;

  assign cix = IW'(cmd.tag);
  assign rsp = res;

  // Link memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    link_rd <= link_mem[mem_raddr];
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rhead   <= '0;
      rtail   <= '0;
      rcount  <= '0;
      whead   <= '0;
      wtail   <= '0;
      wcount  <= '0;
      busy    <= 1'b0;
      busy_wr <= 1'b0;
      cur_tag <= '0;
      pin     <= '0;
      pout    <= '0;
    end else begin
      state   <= state_next;
      rhead   <= rhead_next;
      rtail   <= rtail_next;
      rcount  <= rcount_next;
      whead   <= whead_next;
      wtail   <= wtail_next;
      wcount  <= wcount_next;
      busy    <= busy_next;
      busy_wr <= busy_wr_next;
      cur_tag <= cur_tag_next;
      pin     <= pin_next;
      pout    <= pout_next;
    end
  end

  // Working registers of the request in progress
  always_ff @(posedge clk) begin
    op       <= op_next;
    tag      <= tag_next;
    walk_cur <= walk_cur_next;
    walk_pos <= walk_pos_next;
    pred     <= pred_next;
    take_wr  <= take_wr_next;
    res      <= res_next;
  end

  // Next state, queue updates and memory control
  always_comb begin
    state_next    = state;
    op_next       = op;
    tag_next      = tag;
    rhead_next    = rhead;
    rtail_next    = rtail;
    rcount_next   = rcount;
    whead_next    = whead;
    wtail_next    = wtail;
    wcount_next   = wcount;
    busy_next     = busy;
    busy_wr_next  = busy_wr;
    cur_tag_next  = cur_tag;
    walk_cur_next = walk_cur;
    walk_pos_next = walk_pos;
    pred_next     = pred;
    take_wr_next  = take_wr;
    pin_next      = pin;
    pout_next     = pout;
    res_next      = res;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    cmd_ready     = 1'b0;
    rsp_valid     = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_ready  = 1'b1;
          op_next    = cmd.op;
          tag_next   = cmd.tag;
          res_next   = '0;
          state_next = ST_OUT;
          unique case (cmd.op)
            OP_DONE: begin
              if (!busy) begin
                res_next.error_code = ERR_IDLE;
              end else begin
                res_next.done_valid     = 1'b1;
                res_next.done_tag       = cur_tag;
                res_next.done_was_write = busy_wr;
                if (busy_wr) begin
                  pout_next[IW'(cur_tag)] = 1'b0;
                end else begin
                  pin_next[IW'(cur_tag)] = 1'b0;
                end
                busy_next  = 1'b0;
                state_next = ST_START;
              end
            end
            OP_ENQ_IN, OP_ENQ_OUT: begin
              if (pin[cix] || pout[cix]) begin
                res_next.error_code = ERR_QUEUED;
              end else begin
                // clear the new entry's link, then append
                mem_we     = 1'b1;
                mem_waddr  = cix;
                mem_wdata  = '0;
                state_next = ST_START;
                if (cmd.op == OP_ENQ_IN) begin
                  pin_next[cix] = 1'b1;
                  rcount_next   = rcount + CNT_W'(1);
                  if (rcount == '0) begin
                    rhead_next = cmd.tag;
                    rtail_next = cmd.tag;
                  end else begin
                    state_next = ST_ENQ_LINK;
                  end
                end else begin
                  pout_next[cix] = 1'b1;
                  wcount_next    = wcount + CNT_W'(1);
                  if (wcount == '0) begin
                    whead_next = cmd.tag;
                    wtail_next = cmd.tag;
                  end else begin
                    state_next = ST_ENQ_LINK;
                  end
                end
              end
            end
            OP_RAISE: begin
              if (wcount > CNT_W'(1) && whead != cmd.tag) begin
                mem_raddr     = IW'(whead);
                walk_cur_next = whead;
                walk_pos_next = CNT_W'(1);
                state_next    = ST_WALK;
              end
            end
            OP_DEQ: begin
              if (wcount != '0 && whead == cmd.tag) begin
                mem_raddr  = cix;
                state_next = ST_DEQ_HEAD;
              end else if (wcount > CNT_W'(1)) begin
                mem_raddr     = IW'(whead);
                walk_cur_next = whead;
                walk_pos_next = CNT_W'(1);
                state_next    = ST_WALK;
              end
            end
            default: begin
              state_next = ST_OUT;
            end
          endcase
        end
      end

      ST_ENQ_LINK: begin
        // link the old tail to the new entry
        mem_we    = 1'b1;
        mem_wdata = tag;
        if (op == OP_ENQ_IN) begin
          mem_waddr  = IW'(rtail);
          rtail_next = tag;
        end else begin
          mem_waddr  = IW'(wtail);
          wtail_next = tag;
        end
        state_next = ST_START;
      end

      ST_START: begin
        // start a transfer if the device is free, page-in first
        state_next = ST_OUT;
        if (!busy) begin
          if (rcount != '0) begin
            cur_tag_next  = rhead;
            busy_next     = 1'b1;
            busy_wr_next  = 1'b0;
            rcount_next   = rcount - CNT_W'(1);
            mem_raddr     = IW'(rhead);
            take_wr_next  = 1'b0;
            res_next.start_valid    = 1'b1;
            res_next.start_tag      = rhead;
            res_next.start_is_write = 1'b0;
            state_next    = ST_HEAD;
          end else if (wcount != '0) begin
            cur_tag_next  = whead;
            busy_next     = 1'b1;
            busy_wr_next  = 1'b1;
            wcount_next   = wcount - CNT_W'(1);
            mem_raddr     = IW'(whead);
            take_wr_next  = 1'b1;
            res_next.start_valid    = 1'b1;
            res_next.start_tag      = whead;
            res_next.start_is_write = 1'b1;
            state_next    = ST_HEAD;
          end
        end
      end

      ST_HEAD: begin
        // advance the head past the started entry
        if (take_wr) begin
          whead_next = link_rd;
        end else begin
          rhead_next = link_rd;
        end
        state_next = ST_OUT;
      end

      ST_WALK: begin
        // follow one link per cycle looking for the predecessor
        if (link_rd == tag) begin
          pred_next  = walk_cur;
          mem_raddr  = IW'(tag);
          state_next = ST_SPLICE;
        end else if (walk_pos < wcount - CNT_W'(1)) begin
          walk_cur_next = link_rd;
          walk_pos_next = walk_pos + CNT_W'(1);
          mem_raddr     = IW'(link_rd);
        end else begin
          state_next = ST_OUT;
        end
      end

      ST_SPLICE: begin
        // unlink the entry from behind its predecessor
        mem_we    = 1'b1;
        mem_waddr = IW'(pred);
        mem_wdata = link_rd;
        if (wtail == tag) begin
          wtail_next = pred;
        end
        if (op == OP_RAISE) begin
          state_next = ST_RAISE_FRONT;
        end else begin
          wcount_next             = wcount - CNT_W'(1);
          pout_next[IW'(tag)]     = 1'b0;
          res_next.dequeued       = 1'b1;
          state_next              = ST_OUT;
        end
      end

      ST_RAISE_FRONT: begin
        mem_we     = 1'b1;
        mem_waddr  = IW'(tag);
        mem_wdata  = whead;
        whead_next = tag;
        state_next = ST_OUT;
      end

      ST_DEQ_HEAD: begin
        whead_next          = link_rd;
        wcount_next         = wcount - CNT_W'(1);
        pout_next[IW'(tag)] = 1'b0;
        res_next.dequeued   = 1'b1;
        state_next          = ST_OUT;
      end

      ST_OUT: begin
        // hold the result until taken
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/tqps_checker.sv @@
// Port-level checks of the scheduler, bound to the top level.
module tqps_checker
  import tqps_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result dropped or changed while stalled");

  // No result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result shown right after reset");

  // An error result carries nothing else
  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error_code != ERR_NONE |->
      !rsp.start_valid && !rsp.done_valid && !rsp.dequeued)
    else $error("error result with other fields set");

  // A dequeue never starts or completes a transfer
  a_deq_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.dequeued |-> !rsp.start_valid && !rsp.done_valid)
    else $error("dequeue result with transfer fields set");

  // The finished tag cannot be restarted in the same step
  a_done_start: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.start_valid && rsp.done_valid |-> rsp.start_tag != rsp.done_tag)
    else $error("completed tag started again at once");

endmodule

bind two_queue_page_io_scheduler tqps_checker u_tqps_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
